// ===== sv/bafs_pkg.sv =====
package bafs_pkg;

  // fixed field widths of the block
  localparam int FIELD_W    = 48;
  localparam int SIZE_W     = 13;
  localparam int COUNT_W    = 9;
  localparam int PROD_W     = SIZE_W + COUNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd2;

  localparam logic [SIZE_W-1:0]  SLOT_SIZE_RST  = 13'd32;
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 9'd256;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_DUP   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_POP  = 2'd1,
    RES_BUMP = 2'd2
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     pop;
    logic     mul;
    logic     bump;
    logic     scan_start;
    logic     scan_step;
    logic     push;
    logic     finish;
    res_sel_e res_sel;
    status_e  fin_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic stack_empty;
    logic stack_full;
    logic can_bump;
    logic in_range;
    logic scan_hit;
    logic scan_done;
  } stat_t;

endpackage

// ===== sv/bafs_ram.sv =====
module bafs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/bafs_ctrl.sv =====
module bafs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bafs_pkg::stat_t stat_i,
  output bafs_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_BUMP,
    S_RANGE,
    S_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_sel    = bafs_pkg::RES_ZERO;
    cmd_o.fin_status = bafs_pkg::ST_OK;
    state_d          = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_free) begin
          // multiplier forms the heap span, offset taken alongside
          cmd_o.mul = 1'b1;
          state_d   = S_RANGE;
        end else if (!stat_i.stack_empty) begin
          cmd_o.pop = 1'b1;
          state_d   = S_POP;
        end else if (stat_i.can_bump) begin
          cmd_o.mul = 1'b1;
          state_d   = S_BUMP;
        end else begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = bafs_pkg::ST_FULL;
          state_d          = S_IDLE;
        end
      end
      S_POP: begin
        cmd_o.finish  = 1'b1;
        cmd_o.res_sel = bafs_pkg::RES_POP;
        state_d       = S_IDLE;
      end
      S_BUMP: begin
        cmd_o.bump    = 1'b1;
        cmd_o.finish  = 1'b1;
        cmd_o.res_sel = bafs_pkg::RES_BUMP;
        state_d       = S_IDLE;
      end
      S_RANGE: begin
        if (!stat_i.in_range) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = bafs_pkg::ST_RANGE;
          state_d          = S_IDLE;
        end else if (stat_i.stack_empty) begin
          cmd_o.push   = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        priority if (stat_i.scan_hit) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = bafs_pkg::ST_DUP;
          state_d          = S_IDLE;
        end else if (stat_i.scan_done) begin
          cmd_o.finish = 1'b1;
          if (stat_i.stack_full) begin
            cmd_o.fin_status = bafs_pkg::ST_FULL;
          end else begin
            cmd_o.push = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== sv/bafs_dp.sv =====
module bafs_dp #(
  parameter int MAX_SLOTS = 256,
  parameter int ADDR_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_type_i,
  input  logic [ADDR_BITS-1:0]                free_addr_i,
  input  logic                                cfg_we_i,
  input  logic [bafs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bafs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  bafs_pkg::cmd_t                      cmd_i,
  output bafs_pkg::stat_t                     stat_o,
  output logic [ADDR_BITS-1:0]                slot_addr_o,
  output logic [1:0]                          status_o
);

  localparam int IdxW      = $clog2(MAX_SLOTS);
  localparam int CntW      = $clog2(MAX_SLOTS + 1);
  localparam int CountMax  = (1 << bafs_pkg::COUNT_W) - 1;
  localparam int LiveCap   = (MAX_SLOTS < CountMax) ? MAX_SLOTS : CountMax;
  localparam int FieldBits = (ADDR_BITS < bafs_pkg::FIELD_W) ? ADDR_BITS : bafs_pkg::FIELD_W;
  localparam int CmpW      = (ADDR_BITS > bafs_pkg::PROD_W) ? ADDR_BITS : bafs_pkg::PROD_W;
  localparam logic [ADDR_BITS-1:0] AddrMask = {ADDR_BITS{1'b1}} >> (ADDR_BITS - FieldBits);

  logic [ADDR_BITS-1:0]             heap_base_q;
  logic [bafs_pkg::SIZE_W-1:0]      slot_size_q;
  logic [bafs_pkg::COUNT_W-1:0]     slot_count_q;
  logic [bafs_pkg::COUNT_W-1:0]     next_index_q;
  logic [CntW-1:0]                  free_count_q;
  logic [CntW-1:0]                  scan_idx_q;
  logic                             scan_vld_q;
  logic                             req_type_q;
  logic [ADDR_BITS-1:0]             free_addr_q;
  logic [bafs_pkg::PROD_W-1:0]      prod_q;
  logic [ADDR_BITS-1:0]             offset_q;
  logic                             below_q;
  logic [ADDR_BITS-1:0]             res_addr_q;
  bafs_pkg::status_e                res_status_q;

  logic [bafs_pkg::COUNT_W-1:0]     live;
  logic [bafs_pkg::COUNT_W-1:0]     mul_a;
  logic                             scan_issue;
  logic                             ram_re;
  logic [IdxW-1:0]                  ram_raddr;
  logic [ADDR_BITS-1:0]             ram_rdata;
  logic [ADDR_BITS-1:0]             bump_addr;

  assign live = (slot_count_q > bafs_pkg::COUNT_W'(LiveCap)) ?
                bafs_pkg::COUNT_W'(LiveCap) : slot_count_q;

  // one multiplier: slot offset on allocate, heap span on free
  assign mul_a = req_type_q ? live : next_index_q;

  assign scan_issue = cmd_i.scan_step && (scan_idx_q < free_count_q);
  assign ram_re     = cmd_i.pop || scan_issue;
  assign ram_raddr  = cmd_i.pop ? IdxW'(free_count_q - 1'b1) : scan_idx_q[IdxW-1:0];
  assign bump_addr  = (heap_base_q + ADDR_BITS'(prod_q)) & AddrMask;

  bafs_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (free_count_q[IdxW-1:0]),
    .wdata_i (free_addr_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      slot_size_q  <= bafs_pkg::SLOT_SIZE_RST;
      slot_count_q <= bafs_pkg::SLOT_COUNT_RST;
      next_index_q <= '0;
      free_count_q <= '0;
      scan_idx_q   <= '0;
      scan_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bafs_pkg::CFG_HEAP_BASE:  heap_base_q  <= ADDR_BITS'(cfg_data_i) & AddrMask;
          bafs_pkg::CFG_SLOT_SIZE:  slot_size_q  <= cfg_data_i[bafs_pkg::SIZE_W-1:0];
          bafs_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_data_i[bafs_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.bump) begin
        next_index_q <= next_index_q + 1'b1;
      end
      if (cmd_i.pop) begin
        free_count_q <= free_count_q - 1'b1;
      end else if (cmd_i.push) begin
        free_count_q <= free_count_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        scan_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_vld_q <= scan_issue;
        if (scan_issue) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q  <= req_type_i;
      free_addr_q <= free_addr_i & AddrMask;
    end
    if (cmd_i.mul) begin
      prod_q   <= bafs_pkg::PROD_W'(mul_a) * bafs_pkg::PROD_W'(slot_size_q);
      offset_q <= free_addr_q - heap_base_q;
      below_q  <= (free_addr_q < heap_base_q);
    end
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.fin_status;
      unique case (cmd_i.res_sel)
        bafs_pkg::RES_POP:  res_addr_q <= ram_rdata;
        bafs_pkg::RES_BUMP: res_addr_q <= bump_addr;
        default:            res_addr_q <= '0;
      endcase
    end
  end

  always_comb begin
    stat_o.is_free     = req_type_q;
    stat_o.stack_empty = (free_count_q == '0);
    stat_o.stack_full  = (free_count_q == CntW'(MAX_SLOTS));
    stat_o.can_bump    = (next_index_q < live);
    stat_o.in_range    = !below_q && (CmpW'(offset_q) < CmpW'(prod_q));
    stat_o.scan_hit    = scan_vld_q && (ram_rdata == free_addr_q);
    stat_o.scan_done   = !scan_issue && !scan_vld_q;
  end

  assign slot_addr_o = res_addr_q;
  assign status_o    = res_status_q;

endmodule

// ===== sv/bump_and_free_stack_allocator.sv =====
// Slot allocator: bump pointer over a fixed heap plus a LIFO stack of freed slots.
// Requests: raise start_i with req_type_i (0 allocate, 1 free) and free_addr_i;
// the transfer happens at a clock edge where start_i is high and busy_o is low.
// Each request gives exactly one result: slot_addr_o and status_o are valid for
// the single cycle in which done_o is high. The receiver cannot stall; the
// result must be taken in that cycle, and a new request may start in it.
// An allocate goes from decode to a pop of the free stack or to a bump
// multiply-add; with the heap full it finishes straight from decode.
// A free finishes after its range check when out of range or when the stack is
// empty; otherwise the duplicate scan reads the stack memory one entry per cycle
// through its single read port and stops early on a match.
// Configuration: cfg_valid_i with cfg_index_i (0 heap_base, 1 slot_size,
// 2 slot_count) and cfg_data_i; always ready, write only while idle.
// Reset clears next_index and the stack count and restores heap_base 0,
// slot_size 32, slot_count 256; the stack memory itself is not cleared.
module bump_and_free_stack_allocator #(
  parameter int MAX_SLOTS = 256,
  parameter int ADDR_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            req_type_i,
  input  logic [ADDR_BITS-1:0]            free_addr_i,
  output logic                            done_o,
  output logic [ADDR_BITS-1:0]            slot_addr_o,
  output logic [1:0]                      status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bafs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bafs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bafs_pkg::cmd_t  cmd;
  bafs_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  bafs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  bafs_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (req_type_i),
    .free_addr_i (free_addr_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .slot_addr_o (slot_addr_o),
    .status_o    (status_o)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW          = bafs_pkg::FIELD_W;
  localparam int STACK_DEPTH = 256;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_e;

  typedef struct packed {
    req_kind_e     kind;
    logic [AW-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [AW-1:0]     addr;
    bafs_pkg::status_e st;
  } grant_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            start_i     = 1'b0;
  logic                            req_type_i  = 1'b0;
  logic [AW-1:0]                   free_addr_i = '0;
  logic                            cfg_valid_i = 1'b0;
  logic [bafs_pkg::CFG_IDX_W-1:0]  cfg_index_i = bafs_pkg::CFG_HEAP_BASE;
  logic [bafs_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                            busy_o;
  logic                            done_o;
  logic [AW-1:0]                   slot_addr_o;
  logic [1:0]                      status_o;
  logic                            cfg_ready_o;

  bump_and_free_stack_allocator #(
    .MAX_SLOTS(STACK_DEPTH),
    .ADDR_BITS(AW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_type_i (req_type_i),
    .free_addr_i(free_addr_i),
    .done_o     (done_o),
    .slot_addr_o(slot_addr_o),
    .status_o   (status_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // allocator shadow: configuration and state
  logic [AW-1:0]                mdl_base  = '0;
  logic [bafs_pkg::SIZE_W-1:0]  mdl_size  = bafs_pkg::SLOT_SIZE_RST;
  logic [bafs_pkg::COUNT_W-1:0] mdl_count = bafs_pkg::SLOT_COUNT_RST;
  logic [AW-1:0]      free_stk [STACK_DEPTH];
  int                 free_cnt  = 0;
  int                 next_idx  = 0;
  int                 stk_peak  = 0;

  request_t req_q [$];
  grant_t   grant_q [$];
  request_t nxt_req;
  logic     req_taken  = 1'b0;
  int       burst_left = 0;
  int       gap_left   = 0;
  int       mismatches = 0;
  int       res_idx    = 0;
  int       req_total  = 0;
  int       st_count [4] = '{0, 0, 0, 0};
  int       cycle_cnt  = 0;

  // planned configuration, used to aim free addresses
  logic [AW-1:0] p_base;
  int            p_size;
  int            p_live;

  function automatic grant_t predict_grant(input req_kind_e kind, input logic [AW-1:0] addr);
    grant_t        g;
    int            live;
    logic [AW-1:0] span;
    logic          hit;
    g.addr = '0;
    g.st   = bafs_pkg::ST_OK;
    live   = (mdl_count > STACK_DEPTH) ? STACK_DEPTH : int'(mdl_count);
    span   = AW'(live * mdl_size);
    if (kind == REQ_ALLOC) begin
      if (free_cnt > 0) begin
        free_cnt--;
        g.addr = free_stk[free_cnt];
      end else if (next_idx < live) begin
        g.addr = mdl_base + AW'(next_idx * mdl_size);
        next_idx++;
      end else begin
        g.st = bafs_pkg::ST_FULL;
      end
    end else begin
      hit = 1'b0;
      for (int i = 0; i < free_cnt; i++) begin
        if (free_stk[i] == addr) hit = 1'b1;
      end
      // range test on the offset from base, no wrap
      if (addr < mdl_base || addr - mdl_base >= span) begin
        g.st = bafs_pkg::ST_RANGE;
      end else if (hit) begin
        g.st = bafs_pkg::ST_DUP;
      end else if (free_cnt >= STACK_DEPTH) begin
        g.st = bafs_pkg::ST_FULL;
      end else begin
        free_stk[free_cnt] = addr;
        free_cnt++;
        if (free_cnt > stk_peak) stk_peak = free_cnt;
      end
    end
    return g;
  endfunction

  function automatic logic [AW-1:0] rand_addr();
    return AW'({$urandom, $urandom});
  endfunction

  // driver: bursts of requests separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni || (start_i && !req_taken)) begin
      // hold the pending request
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start_i  <= 1'b0;
    end else if (req_q.size() != 0) begin
      nxt_req = req_q.pop_front();
      start_i     <= 1'b1;
      req_type_i  <= nxt_req.kind;
      free_addr_i <= nxt_req.addr;
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 20);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor: check results, predict accepted requests, track register writes
  always @(posedge clk_i) begin : mon
    grant_t g;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start_i && !busy_o;
      if (done_o) begin
        if (grant_q.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d with nothing expected: slot_addr %h status %0d",
                     res_idx, slot_addr_o, status_o);
          mismatches++;
        end else begin
          g = grant_q.pop_front();
          if (slot_addr_o !== g.addr || status_o !== g.st) begin
            if (mismatches < 10)
              $display("result %0d: slot_addr exp %h got %h, status exp %0d got %0d",
                       res_idx, g.addr, slot_addr_o, g.st, status_o);
            mismatches++;
          end
        end
        res_idx++;
      end
      if (start_i && !busy_o) begin
        g = predict_grant(req_kind_e'(req_type_i), free_addr_i);
        st_count[g.st]++;
        req_total++;
        grant_q = {grant_q, g};
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bafs_pkg::CFG_HEAP_BASE:  mdl_base  = cfg_data_i[AW-1:0];
          bafs_pkg::CFG_SLOT_SIZE:  mdl_size  = cfg_data_i[bafs_pkg::SIZE_W-1:0];
          bafs_pkg::CFG_SLOT_COUNT: mdl_count = cfg_data_i[bafs_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, grant_q.size());
      $display("tb failed");
      $finish;
    end
  end

  task automatic queue_req(input req_kind_e kind, input logic [AW-1:0] addr);
    request_t r;
    r.kind = kind;
    r.addr = addr;
    req_q = {req_q, r};
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_q.size() != 0 || start_i || busy_o || grant_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [bafs_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [bafs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
  endtask

  // only called while idle
  task automatic set_config(input logic [AW-1:0] base,
                            input logic [bafs_pkg::SIZE_W-1:0] size,
                            input logic [bafs_pkg::COUNT_W-1:0] count);
    cfg_write(bafs_pkg::CFG_HEAP_BASE, bafs_pkg::CFG_DATA_W'(base));
    cfg_write(bafs_pkg::CFG_SLOT_SIZE, bafs_pkg::CFG_DATA_W'(size));
    cfg_write(bafs_pkg::CFG_SLOT_COUNT, bafs_pkg::CFG_DATA_W'(count));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    p_base = base;
    p_size = size;
    p_live = (count > STACK_DEPTH) ? STACK_DEPTH : int'(count);
  endtask

  // empty the free stack with allocations, read while idle
  task automatic drain_stack();
    repeat (free_cnt) queue_req(REQ_ALLOC, rand_addr());
  endtask

  initial begin : stim
    int            sel;
    int            k;
    int            tmp;
    int            span;
    int            order [STACK_DEPTH];
    logic [AW-1:0] a;
    logic [bafs_pkg::SIZE_W-1:0]  sz;
    logic [bafs_pkg::COUNT_W-1:0] cnt;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: base 0, 32-byte slots, 256 slots
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_ALLOC, '1);
    queue_req(REQ_FREE, 48'd32);
    queue_req(REQ_FREE, 48'd32);
    queue_req(REQ_FREE, 48'd0);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, 48'd48);
    queue_req(REQ_FREE, 48'd8192);
    queue_req(REQ_FREE, 48'd8191);
    queue_req(REQ_FREE, '1);
    wait_drained();

    // zero slot size, count above depth; old entries now outside the range
    set_config('1, 13'd0, 9'd300);
    drain_stack();
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_ALLOC, '1);
    queue_req(REQ_FREE, '1);
    queue_req(REQ_FREE, '0);
    wait_drained();

    // bump address wraps past the top of the address space
    set_config(48'hFFFF_FFFF_FF00, 13'd4096, 9'd256);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, 48'hFFFF_FFFF_FF00);
    queue_req(REQ_FREE, 48'hFFFF_FFFF_FEFF);
    queue_req(REQ_FREE, '1);
    queue_req(REQ_FREE, 48'h4F00);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_ALLOC, '0);
    wait_drained();

    // zero slot count
    set_config(48'h1000, 13'd16, 9'd0);
    drain_stack();
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, 48'h1000);
    wait_drained();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        a = '1; sz = 13'h1FFF; cnt = 9'h1FF;
      end else if (ph == 1) begin
        a = '0; sz = 13'd1; cnt = 9'd1;
      end else begin
        case ($urandom_range(0, 3))
          0:       a = '0;
          1:       a = '1 - AW'($urandom_range(0, 70000));
          default: a = rand_addr();
        endcase
        case ($urandom_range(0, 4))
          0:       sz = 13'd1;
          1:       sz = 13'h1FFF;
          2:       sz = 13'd0;
          default: sz = bafs_pkg::SIZE_W'($urandom_range(1, 4096));
        endcase
        case ($urandom_range(0, 3))
          0:       cnt = 9'd256;
          1:       cnt = bafs_pkg::COUNT_W'($urandom_range(257, 511));
          default: cnt = bafs_pkg::COUNT_W'($urandom_range(2, 255));
        endcase
      end
      set_config(a, sz, cnt);
      span = p_live * p_size;
      repeat (100) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          queue_req(REQ_ALLOC, rand_addr());
        end else if (sel < 75 && p_live > 0) begin
          // small indexes come back often, so duplicates show up
          k = $urandom_range(0, 1) ? $urandom_range(0, (p_live > 16) ? 15 : p_live - 1)
                                   : $urandom_range(0, p_live - 1);
          queue_req(REQ_FREE, p_base + AW'(k * p_size));
        end else if (sel < 83 && span > 0) begin
          queue_req(REQ_FREE, p_base + AW'($urandom_range(0, span - 1)));
        end else if (sel < 91) begin
          if ($urandom_range(0, 1))
            queue_req(REQ_FREE, p_base + AW'(span) + AW'($urandom_range(0, 7)));
          else
            queue_req(REQ_FREE, p_base - 1 - AW'($urandom_range(0, 7)));
        end else begin
          queue_req(REQ_FREE, rand_addr());
        end
      end
      wait_drained();
    end

    // fill the stack to its depth, then overflow it and pop it empty
    set_config(rand_addr(), 13'd2, 9'd256);
    drain_stack();
    for (int i = 0; i < STACK_DEPTH; i++) order[i] = i;
    for (int i = STACK_DEPTH - 1; i > 0; i--) begin
      k        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    for (int i = 0; i < STACK_DEPTH; i++) queue_req(REQ_FREE, p_base + AW'(2 * order[i]));
    queue_req(REQ_FREE, p_base + AW'(2 * $urandom_range(0, 255) + 1));
    queue_req(REQ_FREE, p_base + AW'(2 * $urandom_range(0, 255)));
    queue_req(REQ_FREE, p_base + AW'(2 * $urandom_range(0, 255)));
    queue_req(REQ_FREE, p_base - 1);
    repeat (STACK_DEPTH + 2) queue_req(REQ_ALLOC, rand_addr());
    wait_drained();

    repeat (STACK_DEPTH + 16) @(posedge clk_i);
    $display("%0d requests: %0d ok, %0d full, %0d out of range, %0d already free",
             req_total, st_count[bafs_pkg::ST_OK], st_count[bafs_pkg::ST_FULL],
             st_count[bafs_pkg::ST_RANGE], st_count[bafs_pkg::ST_DUP]);
    $display("free stack peaked at %0d entries; %0d mismatches", stk_peak, mismatches);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
